/* design/assert_macros.svh */
// Assertion macros shared by the ray / triangle intersection design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RTI_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define RTI_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/rti_pkg.sv */
// Types and constants of the ray / triangle intersection block.
package rti_pkg;

	localparam int COORD_W   = 32;
	localparam int DIR_W     = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIR_W-1:0]   dir_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		coord_t vert0_x;
		coord_t vert0_y;
		coord_t vert0_z;
		coord_t vert1_x;
		coord_t vert1_y;
		coord_t vert1_z;
		coord_t vert2_x;
		coord_t vert2_y;
		coord_t vert2_z;
	} tri_t;

	typedef struct packed {
		logic   hit;
		coord_t distance_t;
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
	} res_t;

endpackage

/* design/ray_triangle_intersection.sv */
// Top level of the pipelined ray / triangle intersection block.
`include "assert_macros.svh"

// Moller-Trumbore ray / triangle test in signed fixed point (FRAC_BITS fraction bits).
// The user must load the ray (origin, direction) through the cfg port while the block
// is idle; the block itself does not enforce this. Each transfer on the tri channel is
// one triangle, and each one gives exactly one transfer on the res channel, in order.
// A miss, including a zero determinant, comes out with hit low and all other fields
// zero. A hit gives t = tnum*2^FRAC_BITS/det (truncated toward zero) and the point
// O + floor(D*t), both saturated to 32 bits. One triangle is accepted per cycle while
// tri_stall is low. The pipe has 45 register stages: eight stages of edge, cross and
// dot products with wide split multiplies and the barycentric test, a divider entry
// stage, a 33-stage restoring divider (one quotient bit per stage), then saturation,
// the D*t multiply and the output register. A stall on res only backs up into the
// pipeline as far as it is full, so bubbles are squeezed out before tri_stall rises.
module ray_triangle_intersection #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tri_valid,
	output logic              tri_stall,
	input  rti_pkg::tri_t     tri_data,
	output logic              res_valid,
	input  logic              res_stall,
	output rti_pkg::res_t     res_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rti_pkg::CFG_DAT_W-1:0] cfg_data
);
	import rti_pkg::*;

	// datapath widths
	localparam int E_W    = COORD_W + 1;          // edges and offset
	localparam int PD_W   = DIR_W + E_W;          // D * E1 product
	localparam int P_W    = PD_W + 1;             // P = D x E1
	localparam int PQ_W   = 2 * E_W;              // T * E0 product
	localparam int Q_W    = PQ_W + 1;             // Q = T x E0
	localparam int PL     = P_W / 2;              // low split of P
	localparam int QL     = E_W + 1;              // low split of Q
	localparam int DL_W   = PL + 1 + E_W;
	localparam int DH_W   = (P_W - PL) + E_W;
	localparam int VL_W   = QL + 1 + DIR_W;
	localparam int VH_W   = (Q_W - QL) + DIR_W;
	localparam int TL_W   = QL + 1 + E_W;
	localparam int TH_W   = (Q_W - QL) + E_W;
	localparam int DET_W  = P_W + E_W + 2;        // det, u, v sums
	localparam int T_W    = Q_W + E_W + 2;        // t numerator sum
	localparam int N_W    = DET_W + 1;            // after sign fix
	localparam int TN_W   = T_W + 1;
	localparam int MAG_W  = T_W;
	localparam int DMAG_W = DET_W;
	localparam int QB     = COORD_W + 1;          // quotient bits kept
	localparam int RW_A   = MAG_W + FRAC_BITS;
	localparam int RW_B   = DMAG_W + QB;
	localparam int RW     = (RW_A > RW_B) ? RW_A : RW_B;
	localparam int PR_W   = DIR_W + COORD_W;
	localparam int PT_W   = PR_W + 1;

	// stage numbers
	localparam int ST_D0 = 9;                     // numerator setup, divider entry
	localparam int ST_T  = ST_D0 + QB + 1;
	localparam int ST_P  = ST_T + 1;
	localparam int NS    = ST_P + 1;

	localparam logic [DIR_W-1:0]   DIR_ONE   = DIR_W'(64'd1 << FRAC_BITS);
	localparam logic [QB-1:0]      T_POS_LIM = QB'(64'h7FFF_FFFF);
	localparam logic [QB-1:0]      T_NEG_LIM = QB'(64'h8000_0000);
	localparam logic [COORD_W-1:0] C_MAX     = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] C_MIN     = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [NS:1]        ALL1      = '1;

	// ray registers
	coord_t org_q [3];
	dir_t   dir_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= DIR_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_X: org_q[0] <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y: org_q[1] <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Z: org_q[2] <= cfg_data[COORD_W-1:0];
				REG_DIR_X:    dir_q[0] <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:    dir_q[1] <= cfg_data[DIR_W-1:0];
				REG_DIR_Z:    dir_q[2] <= cfg_data[DIR_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Flow control: a stage loads when it is empty or some stage past it will move.
	// ---------------------------------------------------------------------------------
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		for (int k = 1; k <= NS; k++) begin
			en[k] = !res_stall || (|(~vld_q & (ALL1 << (k - 1))));
		end
	end

	assign tri_stall = !en[1];
	assign res_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= tri_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: edges E0 = V1-V0, E1 = V2-V0 and offset T = O-V0
	// ---------------------------------------------------------------------------------
	coord_t v0 [3];
	coord_t v1 [3];
	coord_t v2 [3];
	logic signed [E_W-1:0] e0_s1 [3];
	logic signed [E_W-1:0] e1_s1 [3];
	logic signed [E_W-1:0] tv_s1 [3];

	assign v0[0] = tri_data.vert0_x;
	assign v0[1] = tri_data.vert0_y;
	assign v0[2] = tri_data.vert0_z;
	assign v1[0] = tri_data.vert1_x;
	assign v1[1] = tri_data.vert1_y;
	assign v1[2] = tri_data.vert1_z;
	assign v2[0] = tri_data.vert2_x;
	assign v2[1] = tri_data.vert2_y;
	assign v2[2] = tri_data.vert2_z;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				e0_s1[i] <= E_W'(v1[i]) - E_W'(v0[i]);
				e1_s1[i] <= E_W'(v2[i]) - E_W'(v0[i]);
				tv_s1[i] <= E_W'(org_q[i]) - E_W'(v0[i]);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 2: cross product terms of P = D x E1 and Q = T x E0
	// ---------------------------------------------------------------------------------
	logic signed [PD_W-1:0] pd_s2 [6];
	logic signed [PQ_W-1:0] pq_s2 [6];
	logic signed [E_W-1:0]  e0_s2 [3];
	logic signed [E_W-1:0]  e1_s2 [3];
	logic signed [E_W-1:0]  tv_s2 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				pd_s2[2*i]   <= dir_q[(i == 2) ? 0 : i + 1] * e1_s1[(i == 0) ? 2 : i - 1];
				pd_s2[2*i+1] <= dir_q[(i == 0) ? 2 : i - 1] * e1_s1[(i == 2) ? 0 : i + 1];
				pq_s2[2*i]   <= tv_s1[(i == 2) ? 0 : i + 1] * e0_s1[(i == 0) ? 2 : i - 1];
				pq_s2[2*i+1] <= tv_s1[(i == 0) ? 2 : i - 1] * e0_s1[(i == 2) ? 0 : i + 1];
			end
			e0_s2 <= e0_s1;
			e1_s2 <= e1_s1;
			tv_s2 <= tv_s1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 3: P and Q
	// ---------------------------------------------------------------------------------
	logic signed [P_W-1:0] p_s3 [3];
	logic signed [Q_W-1:0] q_s3 [3];
	logic signed [E_W-1:0] e0_s3 [3];
	logic signed [E_W-1:0] e1_s3 [3];
	logic signed [E_W-1:0] tv_s3 [3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= P_W'(pd_s2[2*i]) - P_W'(pd_s2[2*i+1]);
				q_s3[i] <= Q_W'(pq_s2[2*i]) - Q_W'(pq_s2[2*i+1]);
			end
			e0_s3 <= e0_s2;
			e1_s3 <= e1_s2;
			tv_s3 <= tv_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 4: dot product terms, wide operands split in two halves
	// ---------------------------------------------------------------------------------
	logic signed [DL_W-1:0] dl_s4 [3];
	logic signed [DH_W-1:0] dh_s4 [3];
	logic signed [DL_W-1:0] ul_s4 [3];
	logic signed [DH_W-1:0] uh_s4 [3];
	logic signed [VL_W-1:0] vl_s4 [3];
	logic signed [VH_W-1:0] vh_s4 [3];
	logic signed [TL_W-1:0] tl_s4 [3];
	logic signed [TH_W-1:0] th_s4 [3];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				dl_s4[i] <= $signed({1'b0, p_s3[i][PL-1:0]}) * e0_s3[i];
				dh_s4[i] <= $signed(p_s3[i][P_W-1:PL]) * e0_s3[i];
				ul_s4[i] <= $signed({1'b0, p_s3[i][PL-1:0]}) * tv_s3[i];
				uh_s4[i] <= $signed(p_s3[i][P_W-1:PL]) * tv_s3[i];
				vl_s4[i] <= $signed({1'b0, q_s3[i][QL-1:0]}) * dir_q[i];
				vh_s4[i] <= $signed(q_s3[i][Q_W-1:QL]) * dir_q[i];
				tl_s4[i] <= $signed({1'b0, q_s3[i][QL-1:0]}) * e1_s3[i];
				th_s4[i] <= $signed(q_s3[i][Q_W-1:QL]) * e1_s3[i];
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 5: recombine halves
	// ---------------------------------------------------------------------------------
	logic signed [DET_W-1:0] dp_s5 [3];
	logic signed [DET_W-1:0] up_s5 [3];
	logic signed [DET_W-1:0] vp_s5 [3];
	logic signed [T_W-1:0]   tp_s5 [3];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				dp_s5[i] <= (DET_W'(dh_s4[i]) <<< PL) + DET_W'(dl_s4[i]);
				up_s5[i] <= (DET_W'(uh_s4[i]) <<< PL) + DET_W'(ul_s4[i]);
				vp_s5[i] <= (DET_W'(vh_s4[i]) <<< QL) + DET_W'(vl_s4[i]);
				tp_s5[i] <= (T_W'(th_s4[i]) <<< QL) + T_W'(tl_s4[i]);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 6: det = P.E0, u = P.T, v = Q.D, t = Q.E1
	// ---------------------------------------------------------------------------------
	logic signed [DET_W-1:0] det_s6;
	logic signed [DET_W-1:0] un_s6;
	logic signed [DET_W-1:0] vn_s6;
	logic signed [T_W-1:0]   tn_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			det_s6 <= dp_s5[0] + dp_s5[1] + dp_s5[2];
			un_s6  <= up_s5[0] + up_s5[1] + up_s5[2];
			vn_s6  <= vp_s5[0] + vp_s5[1] + vp_s5[2];
			tn_s6  <= tp_s5[0] + tp_s5[1] + tp_s5[2];
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 7: flip all signs when det is negative
	// ---------------------------------------------------------------------------------
	logic signed [N_W-1:0]  det_s7;
	logic signed [N_W-1:0]  un_s7;
	logic signed [N_W-1:0]  vn_s7;
	logic signed [TN_W-1:0] tn_s7;
	logic                   zero_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			zero_s7 <= (det_s6 == '0);
			if (det_s6[DET_W-1]) begin
				det_s7 <= -N_W'(det_s6);
				un_s7  <= -N_W'(un_s6);
				vn_s7  <= -N_W'(vn_s6);
				tn_s7  <= -TN_W'(tn_s6);
			end else begin
				det_s7 <= N_W'(det_s6);
				un_s7  <= N_W'(un_s6);
				vn_s7  <= N_W'(vn_s6);
				tn_s7  <= TN_W'(tn_s6);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 8: barycentric test, |t numerator|
	// ---------------------------------------------------------------------------------
	logic signed [N_W:0]    uv_sum;
	logic signed [TN_W-1:0] tn_abs;
	logic                   hit_s8;
	logic                   tneg_s8;
	logic [MAG_W-1:0]       tmag_s8;
	logic [DMAG_W-1:0]      dmag_s8;

	assign uv_sum = (N_W + 1)'(un_s7) + (N_W + 1)'(vn_s7);
	assign tn_abs = tn_s7[TN_W-1] ? -tn_s7 : tn_s7;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			hit_s8  <= !zero_s7 && !un_s7[N_W-1] && !vn_s7[N_W-1]
				&& (uv_sum <= (N_W + 1)'(det_s7));
			tneg_s8 <= tn_s7[TN_W-1];
			tmag_s8 <= tn_abs[MAG_W-1:0];
			dmag_s8 <= det_s7[DMAG_W-1:0];
		end
	end

	// ---------------------------------------------------------------------------------
	// Divider: entry 0 is stage 9 (numerator shift, overflow check), then one
	// restoring step per stage, quotient MSB first.
	// ---------------------------------------------------------------------------------
	logic [RW-1:0]     rem_sdiv  [QB+1];
	logic [QB-1:0]     quo_sdiv  [QB+1];
	logic [DMAG_W-1:0] dmag_sdiv [QB+1];
	logic              hit_sdiv  [QB+1];
	logic              tneg_sdiv [QB+1];
	logic              ovf_sdiv  [QB+1];

	always_ff @(posedge clk) begin
		if (en[ST_D0]) begin
			rem_sdiv[0]  <= RW'(tmag_s8) << FRAC_BITS;
			quo_sdiv[0]  <= '0;
			dmag_sdiv[0] <= dmag_s8;
			hit_sdiv[0]  <= hit_s8;
			tneg_sdiv[0] <= tneg_s8;
			// quotient would need more than QB bits: saturate
			ovf_sdiv[0]  <= (RW'(tmag_s8) << FRAC_BITS) >= (RW'(dmag_s8) << QB);
		end
	end

	for (genvar n = 1; n <= QB; n++) begin : g_div
		localparam int J = QB - n;
		logic [RW:0] diff;
		logic        ge;

		assign diff = {1'b0, rem_sdiv[n-1]} - {1'b0, RW'(dmag_sdiv[n-1]) << J};
		assign ge   = !diff[RW];

		always_ff @(posedge clk) begin
			if (en[ST_D0 + n]) begin
				rem_sdiv[n]    <= ge ? diff[RW-1:0] : rem_sdiv[n-1];
				quo_sdiv[n]    <= quo_sdiv[n-1] | (QB'(ge) << J);
				dmag_sdiv[n]   <= dmag_sdiv[n-1];
				hit_sdiv[n]    <= hit_sdiv[n-1];
				tneg_sdiv[n]   <= tneg_sdiv[n-1];
				ovf_sdiv[n]    <= ovf_sdiv[n-1];
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 43: signed, saturated t
	// ---------------------------------------------------------------------------------
	logic [QB-1:0] quo_f;
	logic [QB-1:0] quo_neg;
	coord_t        t_s43;
	logic          hit_s43;

	assign quo_f   = quo_sdiv[QB];
	assign quo_neg = -quo_f;

	always_ff @(posedge clk) begin
		if (en[ST_T]) begin
			hit_s43 <= hit_sdiv[QB];
			if (tneg_sdiv[QB]) begin
				t_s43 <= (ovf_sdiv[QB] || quo_f > T_NEG_LIM) ? C_MIN : quo_neg[COORD_W-1:0];
			end else begin
				t_s43 <= (ovf_sdiv[QB] || quo_f > T_POS_LIM) ? C_MAX : quo_f[COORD_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 44: D * t
	// ---------------------------------------------------------------------------------
	logic signed [PR_W-1:0] pr_s44 [3];
	coord_t                 t_s44;
	logic                   hit_s44;

	always_ff @(posedge clk) begin
		if (en[ST_P]) begin
			for (int i = 0; i < 3; i++) begin
				pr_s44[i] <= dir_q[i] * t_s43;
			end
			t_s44   <= t_s43;
			hit_s44 <= hit_s43;
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 45: point = O + floor(D*t), saturated; output register
	// ---------------------------------------------------------------------------------
	logic signed [PT_W-1:0] pt [3];
	coord_t                 pt_sat [3];
	res_t                   res_s45;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt[i] = PT_W'(org_q[i]) + PT_W'(pr_s44[i] >>> FRAC_BITS);
			if (pt[i][PT_W-1:COORD_W-1] == '0 || pt[i][PT_W-1:COORD_W-1] == '1) begin
				pt_sat[i] = pt[i][COORD_W-1:0];
			end else begin
				pt_sat[i] = pt[i][PT_W-1] ? C_MIN : C_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			if (hit_s44) begin
				res_s45.hit        <= 1'b1;
				res_s45.distance_t <= t_s44;
				res_s45.point_x    <= pt_sat[0];
				res_s45.point_y    <= pt_sat[1];
				res_s45.point_z    <= pt_sat[2];
			end else begin
				res_s45 <= '0;
			end
		end
	end

	assign res_data = res_s45;

	// ---------------------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------------------
	logic res_rest_zero;

	assign res_rest_zero = (res_data.distance_t == '0) && (res_data.point_x == '0)
		&& (res_data.point_y == '0) && (res_data.point_z == '0);

	`RTI_CHECK(a_miss_zero, res_valid && !res_data.hit |-> res_rest_zero, "miss with nonzero fields")
	`RTI_CHECK(a_stall_full, tri_stall |-> (&vld_q), "tri stalled while pipeline has a bubble")
	`RTI_CHECK_NEXT(a_out_fill, !vld_q[NS] && vld_q[NS-1], vld_q[NS], "item lost before output")

endmodule
